>>> hw/rtl/spq_pkg.sv
package spq_pkg;

   localparam int PRIO_W        = 8;
   localparam int TAG_W         = 16;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 5;
   localparam int DEFAULT_DEPTH = 16;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic req_ready;
      logic load;
      logic exec;
   } ctrl_type;

   // Status from the datapath back to the sequencer.
   typedef struct packed {
      logic rsp_busy;
   } dp_status_type;

endpackage

>>> hw/rtl/spq_req_if.sv
interface spq_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [spq_pkg::PRIO_W-1:0]  priority_req;
   logic [spq_pkg::TAG_W-1:0]   client_tag;

   modport source (output valid, command, priority_req, client_tag, input ready);
   modport sink   (input valid, command, priority_req, client_tag, output ready);
endinterface

>>> hw/rtl/spq_rsp_if.sv
interface spq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [spq_pkg::STATUS_W-1:0]  status;
   logic [spq_pkg::PRIO_W-1:0]    out_priority;
   logic [spq_pkg::TAG_W-1:0]     out_tag;
   logic [spq_pkg::COUNT_W-1:0]   entry_count;
   logic                          is_empty;

   modport source (output valid, status, out_priority, out_tag, entry_count, is_empty,
                   input ready);
   modport sink   (input valid, status, out_priority, out_tag, entry_count, is_empty,
                   output ready);
endinterface

>>> hw/rtl/spq_ctrl.sv
module spq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  spq_pkg::dp_status_type dp_status,
   output spq_pkg::ctrl_type      ctrl
);

   spq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spq_pkg::S_IDLE: begin
            if (req_valid) state_in = spq_pkg::S_EXEC;
         end
         spq_pkg::S_EXEC: begin
            if (!dp_status.rsp_busy) state_in = spq_pkg::S_IDLE;
         end
         default: state_in = spq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         spq_pkg::S_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.load      = req_valid;
         end
         spq_pkg::S_EXEC: begin
            // The update waits until the result register can take the new result.
            ctrl.exec = !dp_status.rsp_busy;
         end
         default: ctrl = '0;
      endcase
   end

endmodule

>>> hw/rtl/spq_datapath.sv
module spq_datapath #(
   parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::ctrl_type      ctrl,
   output spq_pkg::dp_status_type dp_status,
   spq_req_if.sink                req,
   spq_rsp_if.source              rsp
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // Sorted row of cells, head at index zero.
   spq_pkg::entry_type cell_ff [QUEUE_DEPTH];
   spq_pkg::entry_type cell_in [QUEUE_DEPTH];
   logic [CW-1:0]      count_ff, count_in;

   spq_pkg::cmd_type   cmd_ff;
   spq_pkg::entry_type entry_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type            status_ff, status_in;
   spq_pkg::entry_type             out_ff, out_in;
   logic [CW-1:0]                  rcount_ff;

   logic [QUEUE_DEPTH-1:0] le;
   logic                   full;
   logic                   empty;

   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   // Each occupied cell whose priority is lower or equal keeps its place.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         le[i] = (CW'(i) < count_ff) && (cell_ff[i].prio <= entry_ff.prio);
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = spq_pkg::ST_OK;
      out_in    = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
      end
      if (cmd_ff == spq_pkg::CMD_INSERT) begin
         if (full) begin
            status_in = spq_pkg::ST_FULL;
         end else begin
            count_in = count_ff + CW'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (le[i]) begin
                  cell_in[i] = cell_ff[i];
               end else if (i == 0) begin
                  cell_in[i] = entry_ff;
               end else if (le[i-1]) begin
                  cell_in[i] = entry_ff;
               end else begin
                  cell_in[i] = cell_ff[i-1];
               end
            end
         end
      end else begin
         if (empty) begin
            status_in = spq_pkg::ST_EMPTY;
         end else begin
            count_in = count_ff - CW'(1);
            out_in   = cell_ff[0];
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
               cell_in[i] = cell_ff[i+1];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      if (ctrl.exec)                 rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.exec) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff         <= spq_pkg::cmd_type'(req.command);
         entry_ff.prio  <= req.priority_req;
         entry_ff.tag   <= req.client_tag;
      end
      if (ctrl.exec) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            cell_ff[i] <= cell_in[i];
         end
         status_ff <= status_in;
         out_ff    <= out_in;
         rcount_ff <= count_in;
      end
   end

   assign dp_status.rsp_busy = rsp_valid_ff && !rsp.ready;
   assign req.ready          = ctrl.req_ready;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.out_priority = out_ff.prio;
   assign rsp.out_tag      = out_ff.tag;
   assign rsp.entry_count  = spq_pkg::COUNT_W'(rcount_ff);
   assign rsp.is_empty     = (rcount_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      ctrl.exec |=> rsp_valid_ff)
      else $error("update without a result");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.exec && cmd_ff == spq_pkg::CMD_REMOVE && !empty
      |=> count_ff == $past(count_ff) - CW'(1))
      else $error("remove did not lower the count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(2) |-> cell_ff[0].prio <= cell_ff[1].prio)
      else $error("head cells out of order");

endmodule

>>> hw/rtl/stable_priority_queue.sv
// Stable priority queue held as a sorted row of register cells.
// The req channel carries one command per transaction: insert (priority and
// client tag) or remove the head entry. The rsp channel returns exactly one
// result transaction per command with status, removed entry, entry count
// and an empty flag. A lower priority value leaves first; equal priorities
// leave in arrival order, since an insert lands behind every equal entry.
// Timing: a taken request is latched first and is applied to the cells once
// the result register can take the result, which rsp then presents.
// No new command is taken before the last is applied: a two-state sequencer
// first latches the request and then updates every cell in parallel.
// If the receiver stalls, the result waits in the output register and the
// following command is held in the update state until that register drains,
// so no result is lost or overwritten; req stays ready only while idle.
// Reset (synchronous, active high) empties the queue and drops any pending
// result; the cell contents are left as they are and are never read again
// before being rewritten. Removing from an empty queue or inserting into a
// full one reports an error status and leaves the contents unchanged.
module stable_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);

   spq_pkg::ctrl_type      ctrl;
   spq_pkg::dp_status_type dp_status;

   // Sequencer: decides when a request is latched and when the cells update.
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .dp_status (dp_status),
      .ctrl      (ctrl)
   );

   // Datapath: the cell row, the entry count and the result register.
   spq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .dp_status (dp_status),
      .req       (req),
      .rsp       (rsp)
   );

endmodule

>>> tb/sv/tb_stable_priority_queue.sv
`timescale 1ns / 1ps

module tb_stable_priority_queue;

   localparam int DEPTH        = spq_pkg::DEFAULT_DEPTH;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_TAIL  = 12;

   // One command as the sender holds it. When hold_for_drain is set, the
   // sender keeps the request channel quiet until every outstanding result
   // has come back before it offers this transaction.
   typedef struct {
      spq_pkg::cmd_type           command;
      logic [spq_pkg::PRIO_W-1:0] prio;
      logic [spq_pkg::TAG_W-1:0]  tag;
      bit                         hold_for_drain;
   } queue_cmd_type;

   // The result that the queue ought to return for one command.
   typedef struct {
      spq_pkg::status_type         status;
      logic [spq_pkg::PRIO_W-1:0]  prio;
      logic [spq_pkg::TAG_W-1:0]   tag;
      logic [spq_pkg::COUNT_W-1:0] count;
      logic                        empty;
   } queue_rsp_type;

   logic clock;
   logic reset;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   stable_priority_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // Commands still to be sent, and the results predicted for commands that
   // the queue has already taken, oldest first.
   queue_cmd_type cmd_backlog[$];
   queue_rsp_type predicted_rsp[$];

   // The testbench's own image of the sorted queue contents.
   logic [spq_pkg::PRIO_W-1:0] shadow_prio [DEPTH];
   logic [spq_pkg::TAG_W-1:0]  shadow_tag  [DEPTH];
   int                         shadow_held;

   int  cycle_count;
   int  cmds_taken;
   int  total_cmds;
   int  fault_count;
   int  send_gap;
   int  rsp_stall;
   bit  req_taken;

   // Coverage tallies for the closing summary.
   int  n_inserted;
   int  n_removed;
   int  n_empty_err;
   int  n_full_err;
   int  peak_held;

   always #5 clock = ~clock;

   // Mostly short gaps with the occasional long one. For a stretch at regular
   // intervals both sides run flat out, so that back-to-back transactions are
   // exercised as well.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if ((cycle_count % 4000) < 900) begin
         return 0;
      end
      if (roll < 50) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic void push_cmd(spq_pkg::cmd_type command,
                                    logic [spq_pkg::PRIO_W-1:0] prio,
                                    logic [spq_pkg::TAG_W-1:0] tag, bit hold_for_drain);
      queue_cmd_type item;
      item.command        = command;
      item.prio           = prio;
      item.tag            = tag;
      item.hold_for_drain = hold_for_drain;
      cmd_backlog.push_back(item);
   endfunction

   // Applies one command to the shadow queue and returns what the block
   // should report. An insert walks past every entry whose priority is lower
   // or equal, which keeps equal priorities in arrival order; a remove takes
   // the head. Both error cases leave the contents untouched.
   function automatic queue_rsp_type apply_command(queue_cmd_type item);
      queue_rsp_type outcome;
      int            pos;
      int            i;
      outcome.status = spq_pkg::ST_OK;
      outcome.prio   = '0;
      outcome.tag    = '0;
      if (item.command == spq_pkg::CMD_INSERT) begin
         if (shadow_held >= DEPTH) begin
            outcome.status = spq_pkg::ST_FULL;
            n_full_err++;
         end else begin
            pos = 0;
            while (pos < shadow_held && shadow_prio[pos] <= item.prio) begin
               pos++;
            end
            for (i = shadow_held; i > pos; i--) begin
               shadow_prio[i] = shadow_prio[i-1];
               shadow_tag[i]  = shadow_tag[i-1];
            end
            shadow_prio[pos] = item.prio;
            shadow_tag[pos]  = item.tag;
            shadow_held++;
            n_inserted++;
            if (shadow_held > peak_held) begin
               peak_held = shadow_held;
            end
         end
      end else begin
         if (shadow_held == 0) begin
            outcome.status = spq_pkg::ST_EMPTY;
            n_empty_err++;
         end else begin
            outcome.prio = shadow_prio[0];
            outcome.tag  = shadow_tag[0];
            for (i = 1; i < shadow_held; i++) begin
               shadow_prio[i-1] = shadow_prio[i];
               shadow_tag[i-1]  = shadow_tag[i];
            end
            shadow_held--;
            n_removed++;
         end
      end
      outcome.count = shadow_held[spq_pkg::COUNT_W-1:0];
      outcome.empty = (shadow_held == 0);
      return outcome;
   endfunction

   function automatic void report_fault(string what);
      fault_count++;
      if (fault_count <= 10) begin
         $display("[%0t] mismatch %0d: %s", $time, fault_count, what);
      end
   endfunction

   // Request driver. Everything changes on the falling edge. A transaction
   // on offer is held until the rising edge that accepts it; only then does
   // the driver either idle for the chosen gap or present the next command.
   // The valid line is assigned at most once per falling edge.
   always @(negedge clock) begin : drive_requests
      queue_cmd_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (cmd_backlog.size() != 0 &&
                      !(cmd_backlog[0].hold_for_drain && predicted_rsp.size() != 0)) begin
            item                = cmd_backlog.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.command      <= item.command;
            req_ch.priority_req <= item.prio;
            req_ch.client_tag   <= item.tag;
            send_gap            <= pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result receiver: stalls for a random number of cycles, then raises ready
   // and may stall again only after ready has been high.
   always @(negedge clock) begin : drive_ready
      if (rsp_stall > 0) begin
         rsp_stall    <= rsp_stall - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 99) < 30) begin
            rsp_stall <= pick_gap();
         end
      end
   end

   // Monitor. Both channels are sampled on the rising edge. An accepted
   // result is checked against the oldest prediction before any command
   // taken on the same edge is added, so ordering is always preserved.
   always @(posedge clock) begin : watch_channels
      queue_cmd_type taken;
      queue_rsp_type want;
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_rsp.size() == 0) begin
               report_fault($sformatf("result with none pending: status=%0d prio=%0d tag=%h",
                                      rsp_ch.status, rsp_ch.out_priority, rsp_ch.out_tag));
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.out_priority !== want.prio ||
                   rsp_ch.out_tag !== want.tag || rsp_ch.entry_count !== want.count ||
                   rsp_ch.is_empty !== want.empty) begin
                  report_fault($sformatf({"expected status=%0d prio=%0d tag=%h count=%0d ",
                                          "empty=%0b, got status=%0d prio=%0d tag=%h ",
                                          "count=%0d empty=%0b"},
                                         want.status, want.prio, want.tag, want.count,
                                         want.empty, rsp_ch.status, rsp_ch.out_priority,
                                         rsp_ch.out_tag, rsp_ch.entry_count,
                                         rsp_ch.is_empty));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            taken.command        = spq_pkg::cmd_type'(req_ch.command);
            taken.prio           = req_ch.priority_req;
            taken.tag            = req_ch.client_tag;
            taken.hold_for_drain = 1'b0;
            predicted_rsp.push_back(apply_command(taken));
            cmds_taken <= cmds_taken + 1;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, predicted_rsp.size());
      $display("FAIL stable_priority_queue");
      $finish;
   end

   initial begin : run_test
      int                         n;
      int                         k;
      int                         kind;
      int                         run_len;
      int                         pct_insert;
      int                         sel;
      spq_pkg::cmd_type           cmd;
      logic [spq_pkg::PRIO_W-1:0] p;

      clock               = 1'b0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.command      = spq_pkg::CMD_INSERT;
      req_ch.priority_req = '0;
      req_ch.client_tag   = '0;
      rsp_ch.ready        = 1'b0;
      shadow_held         = 0;
      cycle_count         = 0;
      cmds_taken          = 0;
      fault_count         = 0;
      send_gap            = 0;
      rsp_stall           = 0;
      req_taken           = 1'b0;
      n_inserted          = 0;
      n_removed           = 0;
      n_empty_err         = 0;
      n_full_err          = 0;
      peak_held           = 0;

      // Directed opening. A remove on the empty queue comes first; its
      // priority and tag fields carry junk that must be ignored.
      push_cmd(spq_pkg::CMD_REMOVE, 8'hAA, 16'h5555, 1'b0);
      // Sixteen inserts fill the queue exactly. They mix both priority
      // extremes, both tag extremes and several runs of equal priorities so
      // that the arrival-order rule is visible once the queue drains.
      push_cmd(spq_pkg::CMD_INSERT, 8'd128, 16'h0001, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd255, 16'hFFFF, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd0,   16'h0000, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd128, 16'h0002, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd0,   16'h0003, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd255, 16'h0004, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd7,   16'h1234, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd128, 16'h0005, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd1,   16'hAAAA, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd254, 16'h5555, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd0,   16'h0006, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd128, 16'h0007, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd64,  16'h8000, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd64,  16'h7FFF, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd200, 16'hC3C3, 1'b0);
      push_cmd(spq_pkg::CMD_INSERT, 8'd3,   16'h3C3C, 1'b0);
      // The queue is now full: this insert must be refused.
      push_cmd(spq_pkg::CMD_INSERT, 8'd0, 16'hBEEF, 1'b0);
      for (k = 0; k < 6; k++) begin
         push_cmd(spq_pkg::CMD_REMOVE, 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), 1'b0);
      end

      // Random part, built from runs that lean towards filling, towards
      // draining or towards neither, so that both the full and the empty
      // boundary are reached again and again. Priorities cluster in a narrow
      // band often enough to give plenty of ties. Every 150 commands the
      // sender waits for the queue to go quiet first.
      n = 0;
      while (n < RANDOM_ITEMS) begin
         kind    = $urandom_range(0, 2);
         run_len = $urandom_range(4, 40);
         case (kind)
            0: begin
               pct_insert = 85;
            end
            1: begin
               pct_insert = 20;
            end
            default: begin
               pct_insert = 50;
            end
         endcase
         for (k = 0; k < run_len; k++) begin
            cmd = ($urandom_range(0, 99) < pct_insert) ? spq_pkg::CMD_INSERT
                                                        : spq_pkg::CMD_REMOVE;
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
               p = 8'($urandom_range(0, 7));
            end else if (sel < 50) begin
               p = 8'd0;
            end else if (sel < 55) begin
               p = 8'd255;
            end else begin
               p = 8'($urandom_range(0, 255));
            end
            push_cmd(cmd, p, 16'($urandom_range(0, 65535)), (n % 150) == 0);
            n++;
         end
      end
      total_cmds = cmd_backlog.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every command has been taken, then until every result
      // has been checked, then a short tail to catch any stray result.
      while (cmds_taken < total_cmds) @(negedge clock);
      while (predicted_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_TAIL) @(negedge clock);

      $display("Sent %0d commands in %0d cycles: %0d inserts and %0d removes succeeded,",
               total_cmds, cycle_count, n_inserted, n_removed);
      $display("%0d removes hit an empty queue, %0d inserts hit a full one, peak fill %0d.",
               n_empty_err, n_full_err, peak_held);
      if (fault_count == 0) begin
         $display("PASS stable_priority_queue");
      end else begin
         $display("%0d mismatches in total", fault_count);
         $display("FAIL stable_priority_queue");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_req_if.sv
hw/rtl/spq_rsp_if.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/stable_priority_queue.sv
tb/sv/tb_stable_priority_queue.sv
